FILE: rtl/grid_rectangle_allocator_assert.svh
// ----------------------------------------------------------------------------
// grid_rectangle_allocator_assert.svh
// Assertion macros shared by the allocator's checking code.
// ----------------------------------------------------------------------------
`ifndef GRID_RECTANGLE_ALLOCATOR_ASSERT_SVH
`define GRID_RECTANGLE_ALLOCATOR_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define GRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define GRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gra_pkg.sv
// ----------------------------------------------------------------------------
// gra_pkg
// Grid geometry, operation codes, sequencer states and cell helpers.
// ----------------------------------------------------------------------------
package gra_pkg;

    localparam int GRID_W    = 8;
    localparam int GRID_H    = 8;
    localparam int ID_BITS   = 8;
    localparam int CELLS     = GRID_W * GRID_H;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int X_W       = $clog2(GRID_W);
    localparam int Y_W       = $clog2(GRID_H);
    localparam int COUNT_W   = 7;
    localparam int COUNT_MAX = 127;
    localparam int ENTRY_W   = ID_BITS + X_W + Y_W;

    typedef enum logic [2:0] {
        OP_PLACE_AT     = 3'd0,
        OP_PLACE_FIRST  = 3'd1,
        OP_REMOVE_AT    = 3'd2,
        OP_REMOVE_BY_ID = 3'd3,
        OP_READ_CELL    = 3'd4,
        OP_FIRST_ORIGIN = 3'd5,
        OP_NEXT_ORIGIN  = 3'd6,
        OP_NOP          = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT,
        S_WR,
        S_RD,
        S_CHK,
        S_CRD,
        S_CCHK,
        S_DONE
    } t_state;

    // Cells are numbered column by column, which is also the scan order.
    function automatic logic [CELL_W-1:0] cell_idx(input int x, input int y);
        return CELL_W'(x * GRID_H + y);
    endfunction

endpackage

FILE: rtl/grid_rectangle_allocator.sv
// ----------------------------------------------------------------------------
// grid_rectangle_allocator
// Occupancy grid of tagged rectangles with place, first-fit place, remove,
// read and origin walk, driven by a cell-by-cell sequencer.
// ----------------------------------------------------------------------------
// place_at checks its origin and on success sweeps the grid to write it;
// first-fit tries one origin a cycle (up to 64) before the same sweep; reads
// and origin walks read, then check, each cell visited (one cell RAM read port);
// removals add a clearing sweep. One item at a time; the input stalls until it
// completes. Synchronous active-low reset empties grid, count and mode at once.
module grid_rectangle_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_op,
    input  logic [7:0] i_item_id,
    input  logic [2:0] i_pos_x,
    input  logic [2:0] i_pos_y,
    input  logic [3:0] i_size_w,
    input  logic [3:0] i_size_h,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_ok,
    output logic [7:0] o_found_id,
    output logic [2:0] o_found_x,
    output logic [2:0] o_found_y,
    output logic [6:0] o_held_count,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import gra_pkg::*;

    t_state               r_state, n_state;
    t_op                  r_op;
    logic [ID_BITS-1:0]   r_id;
    logic [X_W-1:0]       r_sx, n_sx;
    logic [Y_W-1:0]       r_sy, n_sy;
    logic [3:0]           r_w, r_h;
    logic [CELLS-1:0]     r_occ, r_mask;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_mode;
    logic                 r_ok;
    logic [ID_BITS-1:0]   r_fid;
    logic [X_W-1:0]       r_fx;
    logic [Y_W-1:0]       r_fy;
    logic [ENTRY_W-1:0]   r_mem [CELLS];
    logic [ENTRY_W-1:0]   r_rd;
    logic                 r_ovalid;

    logic [CELL_W-1:0]    ci;
    logic                 last;
    logic [CELLS-1:0]     mask;
    logic                 fits;
    logic                 allowed;
    logic                 place_hit;
    logic [ID_BITS-1:0]   rd_owner;
    logic [X_W-1:0]       rd_ox;
    logic [Y_W-1:0]       rd_oy;
    logic                 occ_c;
    logic                 match;
    logic                 clr_hit;
    logic                 is_remove;
    logic                 single;
    logic                 accept;
    logic                 ld_out;
    logic                 mem_we;
    t_state               start_state;
    logic [X_W-1:0]       start_x;
    logic [Y_W-1:0]       start_y;
    logic [X_W-1:0]       adv_x;
    logic [Y_W-1:0]       adv_y;

    // Shared occupancy and bounds checker.
    gra_fit_unit u_fit (
        .i_x    (r_sx),
        .i_y    (r_sy),
        .i_w    (r_w),
        .i_h    (r_h),
        .i_occ  (r_occ),
        .o_mask (mask),
        .o_fits (fits)
    );

    // Cell cursor and its step in scan order.
    assign ci    = cell_idx(int'(r_sx), int'(r_sy));
    assign last  = (int'(r_sx) == GRID_W - 1) && (int'(r_sy) == GRID_H - 1);
    assign adv_x = (int'(r_sy) == GRID_H - 1) ? X_W'(r_sx + 1'b1) : r_sx;
    assign adv_y = (int'(r_sy) == GRID_H - 1) ? '0 : Y_W'(r_sy + 1'b1);

    // Placement admission and cell comparisons.
    assign allowed   = (r_id != '0) && !(r_mode && (r_count != '0)) &&
                       (int'(r_count) < COUNT_MAX);
    assign place_hit = allowed && fits;
    assign rd_owner  = r_rd[ENTRY_W-1 -: ID_BITS];
    assign rd_ox     = r_rd[X_W+Y_W-1 -: X_W];
    assign rd_oy     = r_rd[Y_W-1:0];
    assign occ_c     = r_occ[ci];
    assign clr_hit   = occ_c && (rd_ox == r_fx) && (rd_oy == r_fy);
    assign is_remove = (r_op == OP_REMOVE_AT) || (r_op == OP_REMOVE_BY_ID);
    assign single    = (r_op == OP_REMOVE_AT) || (r_op == OP_READ_CELL);

    always_comb begin
        case (r_op)
            OP_REMOVE_AT, OP_READ_CELL:       match = occ_c;
            OP_REMOVE_BY_ID:                  match = occ_c && (rd_owner == r_id);
            OP_FIRST_ORIGIN, OP_NEXT_ORIGIN:  match = occ_c && (rd_ox == r_sx) &&
                                                      (rd_oy == r_sy);
            default:                          match = 1'b0;
        endcase
    end

    // Where a new beat starts its work.
    always_comb begin
        start_state = S_DONE;
        start_x     = '0;
        start_y     = '0;
        unique case (t_op'(i_op))
            OP_PLACE_AT: begin
                start_state = S_FIT;
                start_x     = X_W'(i_pos_x);
                start_y     = Y_W'(i_pos_y);
            end
            OP_PLACE_FIRST: begin
                start_state = S_FIT;
            end
            OP_REMOVE_AT, OP_READ_CELL: begin
                if (int'(i_pos_x) < GRID_W && int'(i_pos_y) < GRID_H) begin
                    start_state = S_RD;
                    start_x     = X_W'(i_pos_x);
                    start_y     = Y_W'(i_pos_y);
                end
            end
            OP_REMOVE_BY_ID: begin
                if (i_item_id[ID_BITS-1:0] != '0) start_state = S_RD;
            end
            OP_FIRST_ORIGIN: begin
                start_state = S_RD;
            end
            OP_NEXT_ORIGIN: begin
                if (int'(i_pos_y) >= GRID_H - 1) begin
                    if (int'(i_pos_x) < GRID_W - 1) begin
                        start_state = S_RD;
                        start_x     = X_W'(i_pos_x + 3'd1);
                    end
                end else begin
                    start_state = S_RD;
                    start_x     = X_W'(i_pos_x);
                    start_y     = Y_W'(i_pos_y + 3'd1);
                end
            end
            default: start_state = S_DONE;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = start_state;
            S_FIT: begin
                if (place_hit) n_state = S_WR;
                else if (!allowed || r_op == OP_PLACE_AT || last) n_state = S_DONE;
            end
            S_WR:   if (last) n_state = S_DONE;
            S_RD:   n_state = S_CHK;
            S_CHK: begin
                if (match) n_state = is_remove ? S_CRD : S_DONE;
                else if (single || last) n_state = S_DONE;
                else n_state = S_RD;
            end
            S_CRD:  n_state = S_CCHK;
            S_CCHK: n_state = last ? S_DONE : S_CRD;
            S_DONE: if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        accept     = 1'b0;
        ld_out     = 1'b0;
        mem_we     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                accept     = i_in_valid;
            end
            S_WR:   mem_we = r_mask[ci];
            S_DONE: ld_out = !r_ovalid || !i_out_stall;
            default: o_in_stall = 1'b1;
        endcase
    end

    // Cursor movement.
    always_comb begin
        n_sx = r_sx;
        n_sy = r_sy;
        case (r_state)
            S_IDLE: begin
                n_sx = start_x;
                n_sy = start_y;
            end
            S_FIT: begin
                n_sx = place_hit ? '0 : adv_x;
                n_sy = place_hit ? '0 : adv_y;
            end
            S_CHK: begin
                n_sx = match ? '0 : adv_x;
                n_sy = match ? '0 : adv_y;
            end
            S_WR, S_CCHK: begin
                n_sx = adv_x;
                n_sy = adv_y;
            end
            default: begin
                n_sx = r_sx;
                n_sy = r_sy;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_count  <= '0;
            r_mode   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (r_state == S_WR && last) begin
                r_occ   <= r_occ | r_mask;
                r_count <= COUNT_W'(r_count + 1'b1);
            end
            if (r_state == S_CCHK) begin
                if (clr_hit) r_occ[ci] <= 1'b0;
                if (last && r_count != '0) r_count <= COUNT_W'(r_count - 1'b1);
            end
            if (ld_out) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    // Item and result registers.
    always_ff @(posedge i_clk) begin
        r_sx <= n_sx;
        r_sy <= n_sy;
        if (accept) begin
            r_op  <= t_op'(i_op);
            r_id  <= i_item_id[ID_BITS-1:0];
            r_w   <= i_size_w;
            r_h   <= i_size_h;
            r_ok  <= 1'b0;
            r_fid <= '0;
            r_fx  <= '0;
            r_fy  <= '0;
        end
        if (r_state == S_FIT && place_hit) begin
            r_mask <= mask;
            r_ok   <= 1'b1;
            r_fid  <= r_id;
            r_fx   <= r_sx;
            r_fy   <= r_sy;
        end
        if (r_state == S_CHK && match) begin
            r_ok  <= 1'b1;
            r_fid <= rd_owner;
            r_fx  <= rd_ox;
            r_fy  <= rd_oy;
        end
        if (ld_out) begin
            o_ok         <= r_ok;
            o_found_id   <= 8'(r_fid);
            o_found_x    <= 3'(r_fx);
            o_found_y    <= 3'(r_fy);
            o_held_count <= r_count;
        end
    end

    // Cell RAM: owner and origin, one port addressed by the cursor.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[ci] <= {r_id, r_fx, r_fy};
        r_rd <= r_mem[ci];
    end

    assign o_out_valid = r_ovalid;
    assign o_cfg_ready = 1'b1;

`include "grid_rectangle_allocator_assert.svh"

    // The count runs ahead of the cells only while a clearing sweep is under way.
    `GRA_ASSERT_SAME(a_count_cells, (r_state != S_CRD) && (r_state != S_CCHK), $countones(r_occ) >= int'(r_count), "count exceeds cells")
    `GRA_ASSERT_SAME(a_fail_zero, o_out_valid && !o_ok, o_found_id == 8'd0 && o_found_x == 3'd0 && o_found_y == 3'd0, "failed result not zero")
    `GRA_ASSERT_NEXT(a_busy_after, accept, o_in_stall, "not busy after accept")

endmodule

FILE: rtl/gra_fit_unit.sv
// ----------------------------------------------------------------------------
// gra_fit_unit
// Builds the cell mask of a rectangle and checks that it lies in the grid
// and covers only free cells.
// ----------------------------------------------------------------------------
module gra_fit_unit (
    input  logic [gra_pkg::X_W-1:0]   i_x,
    input  logic [gra_pkg::Y_W-1:0]   i_y,
    input  logic [3:0]                i_w,
    input  logic [3:0]                i_h,
    input  logic [gra_pkg::CELLS-1:0] i_occ,
    output logic [gra_pkg::CELLS-1:0] o_mask,
    output logic                      o_fits
);
    import gra_pkg::*;

    logic [5:0] x_end;
    logic [5:0] y_end;

    // Far edges of the rectangle, one past the last column and row.
    assign x_end = 6'(i_x) + 6'(i_w);
    assign y_end = 6'(i_y) + 6'(i_h);

    // Every cell compares itself against the rectangle bounds.
    always_comb begin
        o_mask = '0;
        for (int j = 0; j < GRID_W; j++) begin
            for (int k = 0; k < GRID_H; k++) begin
                o_mask[cell_idx(j, k)] = (6'(j) >= 6'(i_x)) && (6'(j) < x_end) &&
                                         (6'(k) >= 6'(i_y)) && (6'(k) < y_end);
            end
        end
    end

    // Non-zero size, inside the grid and no covered cell held.
    assign o_fits = (i_w != 4'd0) && (i_h != 4'd0) &&
                    (x_end <= 6'(GRID_W)) && (y_end <= 6'(GRID_H)) &&
                    ((o_mask & i_occ) == '0);

endmodule
